[rtl/core/clt_pkg.sv]
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Shared types and character constants for the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

  // Parser phase within one line.
  typedef enum logic [3:0] {
    PH_LEAD      = 4'd0,
    PH_CMD       = 4'd1,
    PH_SEP       = 4'd2,
    PH_SLASH1    = 4'd3,
    PH_SLASH2    = 4'd4,
    PH_NAME      = 4'd5,
    PH_TOKEN     = 4'd6,
    PH_ESC       = 4'd7,
    PH_ESC_FIRST = 4'd8,
    PH_ERROR     = 4'd9
  } phase_e;

  // Kind of character delivered by one byte.
  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_CMD       = 3'd1,
    KIND_OPT_NAME  = 3'd2,
    KIND_OPT_VALUE = 3'd3,
    KIND_ARG       = 3'd4
  } kind_e;

  // Line verdict.
  typedef enum logic [1:0] {
    ST_BUSY   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_OPTIONS   = 2'd0;
  localparam logic [1:0] REG_MAX_ARGUMENTS = 2'd1;
  localparam logic [1:0] REG_MAX_LINE_LEN  = 2'd2;

  // Character constants.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam logic [15:0] BYTE_CNT_MAX = 16'hFFFF;

  // Per-line parser state.
  typedef struct packed {
    phase_e      phase;
    logic        value_pending;
    logic [7:0]  option_count;
    logic [7:0]  argument_count;
    logic [15:0] byte_count;
  } parse_state_t;

  // Configuration limits.
  typedef struct packed {
    logic [7:0]  max_options;
    logic [7:0]  max_arguments;
    logic [15:0] max_line_len;
  } limits_t;

  // One result word.
  typedef struct packed {
    status_e    status;
    logic [7:0] char_out;
    kind_e      char_kind;
    logic       token_start;
    logic [7:0] token_index;
    logic       value_expected;
  } result_t;

endpackage

[rtl/core/command_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// Command line tokenizer
// Splits a console line into command, options and arguments, byte by byte.
// ----------------------------------------------------------------------------
// Each accepted byte produces exactly one result word in the following cycle:
// the unescaped character with its token kind and index, or, for the zero
// terminator, the accept or reject verdict for the whole line. The block takes
// one byte every clock cycle; while a word is stalled the byte channel is
// stalled too. The only loop is the update of the parser state registers. A new
// byte enters in the same cycle that the previous word is taken. The user must
// write limits through the configuration port only while no line byte is in
// flight (the block does not check); a write takes effect for the next byte.
module command_line_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Line byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  char_out_o,
  output logic [2:0]  char_kind_o,
  output logic        token_start_o,
  output logic [7:0]  token_index_o,
  output logic        value_expected_o,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import clt_pkg::*;

  parse_state_t state_q, state_d;
  limits_t      limits_q, limits_d;
  result_t      result_q, result_d;
  logic         out_valid_q, out_valid_d;
  logic         in_fire;

  // A byte is taken whenever the output word is free or leaves this cycle.
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  clt_step u_step (
    .ch_i     (ch_i),
    .state_i  (state_q),
    .limits_i (limits_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Configuration write decode.
  always_comb begin
    limits_d = limits_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MAX_OPTIONS:   limits_d.max_options   = cfg_data_i[7:0];
        REG_MAX_ARGUMENTS: limits_d.max_arguments = cfg_data_i[7:0];
        REG_MAX_LINE_LEN:  limits_d.max_line_len  = cfg_data_i;
        default:           limits_d = limits_q;
      endcase
    end
  end

  // Output word valid tracking.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= PH_LEAD;
      state_q.value_pending  <= 1'b0;
      state_q.option_count   <= '0;
      state_q.argument_count <= '0;
      state_q.byte_count     <= '0;
      limits_q.max_options   <= 8'd8;
      limits_q.max_arguments <= 8'd8;
      limits_q.max_line_len  <= 16'd256;
      out_valid_q            <= 1'b0;
    end else begin
      limits_q    <= limits_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        state_q <= state_d;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = result_q.status;
  assign char_out_o       = result_q.char_out;
  assign char_kind_o      = result_q.char_kind;
  assign token_start_o    = result_q.token_start;
  assign token_index_o    = result_q.token_index;
  assign value_expected_o = result_q.value_expected;

endmodule

[rtl/core/clt_step.sv]
// ----------------------------------------------------------------------------
// Command line tokenizer step
// Combinational next state and result for one line byte.
// ----------------------------------------------------------------------------
module clt_step (
  input  logic [7:0]            ch_i,
  input  clt_pkg::parse_state_t state_i,
  input  clt_pkg::limits_t      limits_i,
  output clt_pkg::parse_state_t state_o,
  output clt_pkg::result_t      result_o
);
  import clt_pkg::*;

  logic        is_alnum;
  logic        is_graphic;
  logic        is_space;
  logic        arg_ok;
  logic [7:0]  arg_next;
  logic [7:0]  emit_index;
  logic        opt_ok;
  logic [15:0] byte_cnt_inc;
  logic        phase_ok;
  logic        len_ok;

  // Character classes and shared token bookkeeping.
  always_comb begin
    is_alnum   = ((ch_i >= CH_UA) && (ch_i <= CH_UZ)) ||
                 ((ch_i >= CH_LA) && (ch_i <= CH_LZ)) ||
                 ((ch_i >= CH_D0) && (ch_i <= CH_D9));
    is_graphic = (ch_i > CH_SPACE) && (ch_i <= CH_TILDE);
    is_space   = (ch_i == CH_SPACE);
    // A value token fills a pending option and does not use an argument slot.
    arg_ok     = state_i.value_pending || (state_i.argument_count < limits_i.max_arguments);
    arg_next   = state_i.value_pending ? state_i.argument_count
                                       : state_i.argument_count + 8'd1;
    opt_ok     = is_alnum && (state_i.option_count < limits_i.max_options);
    // Index of the token currently being filled with argument or value characters.
    emit_index = state_i.value_pending ? state_i.option_count - 8'd1
                                       : state_i.argument_count - 8'd1;
    byte_cnt_inc = (state_i.byte_count == BYTE_CNT_MAX) ? state_i.byte_count
                                                        : state_i.byte_count + 16'd1;
  end

  // Verdict of the terminator.
  always_comb begin
    case (state_i.phase)
      PH_CMD, PH_TOKEN: phase_ok = 1'b1;
      PH_SEP, PH_NAME:  phase_ok = !state_i.value_pending;
      default:          phase_ok = 1'b0;
    endcase
    len_ok = (byte_cnt_inc <= limits_i.max_line_len) && (byte_cnt_inc != BYTE_CNT_MAX);
  end

  // Phase update and delivered character.
  always_comb begin
    state_o            = state_i;
    state_o.byte_count = byte_cnt_inc;
    result_o           = '0;
    result_o.status    = ST_BUSY;
    result_o.char_kind = KIND_NONE;

    if (ch_i == CH_NUL) begin
      result_o.status        = (phase_ok && len_ok) ? ST_ACCEPT : ST_REJECT;
      state_o.phase          = PH_LEAD;
      state_o.value_pending  = 1'b0;
      state_o.option_count   = '0;
      state_o.argument_count = '0;
      state_o.byte_count     = '0;
    end else begin
      case (state_i.phase)
        PH_LEAD: begin
          if (is_alnum) begin
            state_o.phase        = PH_CMD;
            result_o.char_out    = ch_i;
            result_o.char_kind   = KIND_CMD;
            result_o.token_start = 1'b1;
          end else if (!is_space) begin
            state_o.phase = PH_ERROR;
          end
        end
        PH_CMD: begin
          if (is_space) begin
            state_o.phase = PH_SEP;
          end else if (is_alnum) begin
            result_o.char_out  = ch_i;
            result_o.char_kind = KIND_CMD;
          end else begin
            state_o.phase = PH_ERROR;
          end
        end
        PH_SEP: begin
          if (is_space) begin
            state_o.phase = PH_SEP;
          end else if (ch_i == CH_SLASH) begin
            state_o.phase = state_i.value_pending ? PH_ERROR : PH_SLASH1;
          end else if ((ch_i == CH_BSL) || is_graphic) begin
            if (arg_ok) begin
              state_o.argument_count = arg_next;
              if (ch_i == CH_BSL) begin
                state_o.phase = PH_ESC_FIRST;
              end else begin
                state_o.phase        = PH_TOKEN;
                result_o.char_out    = ch_i;
                result_o.token_start = 1'b1;
                if (state_i.value_pending) begin
                  result_o.char_kind   = KIND_OPT_VALUE;
                  result_o.token_index = state_i.option_count - 8'd1;
                end else begin
                  result_o.char_kind   = KIND_ARG;
                  result_o.token_index = state_i.argument_count;
                end
              end
            end else begin
              state_o.phase = PH_ERROR;
            end
          end else begin
            state_o.phase = PH_ERROR;
          end
        end
        PH_SLASH1, PH_SLASH2: begin
          if ((state_i.phase == PH_SLASH1) && (ch_i == CH_SLASH)) begin
            state_o.phase = PH_SLASH2;
          end else if (opt_ok) begin
            state_o.phase           = PH_NAME;
            state_o.option_count    = state_i.option_count + 8'd1;
            state_o.value_pending   = (state_i.phase == PH_SLASH1);
            result_o.char_out       = ch_i;
            result_o.char_kind      = KIND_OPT_NAME;
            result_o.token_start    = 1'b1;
            result_o.token_index    = state_i.option_count;
            result_o.value_expected = (state_i.phase == PH_SLASH1);
          end else begin
            state_o.phase = PH_ERROR;
          end
        end
        PH_NAME: begin
          if (is_space) begin
            state_o.phase = PH_SEP;
          end else if (is_alnum) begin
            result_o.char_out       = ch_i;
            result_o.char_kind      = KIND_OPT_NAME;
            result_o.token_index    = state_i.option_count - 8'd1;
            result_o.value_expected = state_i.value_pending;
          end else begin
            state_o.phase = PH_ERROR;
          end
        end
        PH_TOKEN: begin
          if (is_space) begin
            state_o.value_pending = 1'b0;
            state_o.phase         = PH_SEP;
          end else if (ch_i == CH_BSL) begin
            state_o.phase = PH_ESC;
          end else if (is_graphic) begin
            result_o.char_out    = ch_i;
            result_o.char_kind   = state_i.value_pending ? KIND_OPT_VALUE : KIND_ARG;
            result_o.token_index = emit_index;
          end else begin
            state_o.phase = PH_ERROR;
          end
        end
        PH_ESC, PH_ESC_FIRST: begin
          if (is_space || (ch_i == CH_BSL) || (ch_i == CH_SLASH)) begin
            state_o.phase        = PH_TOKEN;
            result_o.char_out    = ch_i;
            result_o.char_kind   = state_i.value_pending ? KIND_OPT_VALUE : KIND_ARG;
            result_o.token_index = emit_index;
            result_o.token_start = (state_i.phase == PH_ESC_FIRST);
          end else begin
            state_o.phase = PH_ERROR;
          end
        end
        default: begin
          state_o.phase = PH_ERROR;
        end
      endcase
    end
  end

endmodule

[sim/command_line_tokenizer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer checker
// Watches the byte, result and register channels of the tokenizer, keeps its
// own copy of the line parser and the limits, and compares every result word
// with the word it predicts for the byte that caused it.
// ----------------------------------------------------------------------------
module command_line_tokenizer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Line byte channel
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  ch_i,
  // Result channel
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  char_out_i,
  input  logic [2:0]  char_kind_i,
  input  logic        token_start_i,
  input  logic [7:0]  token_index_i,
  input  logic        value_expected_i,
  // Register write channel
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Totals for the verdict
  output int          fail_count_o,
  output int          pending_o,
  output int          words_o,
  output int          accepts_o,
  output int          rejects_o
);
  import clt_pkg::*;

  // Shadow copies of the limits and of the per-line parser state.
  limits_t      lim;
  parse_state_t ps;

  // Result words predicted but not yet seen on the result channel.
  result_t      predicted_q[$];
  result_t      want;
  int           fails;
  int           words;
  int           accepts;
  int           rejects;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ) ||
           (c >= CH_D0 && c <= CH_D9);
  endfunction

  function automatic logic is_graphic(input logic [7:0] c);
    return c > CH_SPACE && c <= CH_TILDE;
  endfunction

  // Back to the start of a line.
  function automatic void clear_line();
    ps.phase          = PH_LEAD;
    ps.value_pending  = 1'b0;
    ps.option_count   = 8'd0;
    ps.argument_count = 8'd0;
    ps.byte_count     = 16'd0;
  endfunction

  // Opening an argument or value token; a value token uses no argument slot.
  function automatic logic claim_token_slot();
    if (ps.value_pending) return 1'b1;
    if (ps.argument_count >= lim.max_arguments) return 1'b0;
    ps.argument_count = ps.argument_count + 8'd1;
    return 1'b1;
  endfunction

  // A character of an argument or of an option value.
  function automatic result_t token_char(input logic [7:0] c, input logic first);
    result_t r;
    r             = '0;
    r.char_out    = c;
    r.token_start = first;
    if (ps.value_pending) begin
      r.char_kind   = KIND_OPT_VALUE;
      r.token_index = ps.option_count - 8'd1;
    end else begin
      r.char_kind   = KIND_ARG;
      r.token_index = ps.argument_count - 8'd1;
    end
    return r;
  endfunction

  // First character of an option name, in the one or two slash form.
  function automatic result_t open_option(input logic [7:0] c, input logic single);
    result_t r;
    r = '0;
    if (!is_alnum(c) || ps.option_count >= lim.max_options) begin
      ps.phase = PH_ERROR;
    end else begin
      ps.option_count   = ps.option_count + 8'd1;
      ps.value_pending  = single;
      ps.phase          = PH_NAME;
      r.char_out        = c;
      r.char_kind       = KIND_OPT_NAME;
      r.token_start     = 1'b1;
      r.token_index     = ps.option_count - 8'd1;
      r.value_expected  = single;
    end
    return r;
  endfunction

  // Advances the shadow parser by one byte and returns the word it yields.
  function automatic result_t tokenize_byte(input logic [7:0] c);
    result_t r;
    logic    ok;
    r  = '0;
    ok = 1'b0;
    if (ps.byte_count != BYTE_CNT_MAX) ps.byte_count = ps.byte_count + 16'd1;

    // The terminator gives the verdict for the whole line.
    if (c == CH_NUL) begin
      case (ps.phase)
        PH_CMD, PH_TOKEN: ok = 1'b1;
        PH_SEP, PH_NAME:  ok = !ps.value_pending;
        default:          ok = 1'b0;
      endcase
      if (ps.byte_count > lim.max_line_len || ps.byte_count == BYTE_CNT_MAX) ok = 1'b0;
      if (ok) r.status = ST_ACCEPT;
      else r.status = ST_REJECT;
      clear_line();
      return r;
    end

    case (ps.phase)
      PH_LEAD: begin
        if (c != CH_SPACE) begin
          if (is_alnum(c)) begin
            ps.phase      = PH_CMD;
            r.char_out    = c;
            r.char_kind   = KIND_CMD;
            r.token_start = 1'b1;
          end else begin
            ps.phase = PH_ERROR;
          end
        end
      end
      PH_CMD: begin
        if (c == CH_SPACE) begin
          ps.phase = PH_SEP;
        end else if (is_alnum(c)) begin
          r.char_out  = c;
          r.char_kind = KIND_CMD;
        end else begin
          ps.phase = PH_ERROR;
        end
      end
      PH_SEP: begin
        if (c == CH_SPACE) begin
          // More separator.
        end else if (c == CH_SLASH) begin
          if (ps.value_pending) ps.phase = PH_ERROR;
          else ps.phase = PH_SLASH1;
        end else if (c == CH_BSL) begin
          if (claim_token_slot()) ps.phase = PH_ESC_FIRST;
          else ps.phase = PH_ERROR;
        end else if (is_graphic(c)) begin
          if (claim_token_slot()) begin
            ps.phase = PH_TOKEN;
            r        = token_char(c, 1'b1);
          end else begin
            ps.phase = PH_ERROR;
          end
        end else begin
          ps.phase = PH_ERROR;
        end
      end
      PH_SLASH1: begin
        if (c == CH_SLASH) ps.phase = PH_SLASH2;
        else r = open_option(c, 1'b1);
      end
      PH_SLASH2: begin
        r = open_option(c, 1'b0);
      end
      PH_NAME: begin
        if (c == CH_SPACE) begin
          ps.phase = PH_SEP;
        end else if (is_alnum(c)) begin
          r.char_out       = c;
          r.char_kind      = KIND_OPT_NAME;
          r.token_index    = ps.option_count - 8'd1;
          r.value_expected = ps.value_pending;
        end else begin
          ps.phase = PH_ERROR;
        end
      end
      PH_TOKEN: begin
        if (c == CH_SPACE) begin
          ps.value_pending = 1'b0;
          ps.phase         = PH_SEP;
        end else if (c == CH_BSL) begin
          ps.phase = PH_ESC;
        end else if (is_graphic(c)) begin
          r = token_char(c, 1'b0);
        end else begin
          ps.phase = PH_ERROR;
        end
      end
      PH_ESC, PH_ESC_FIRST: begin
        if (c == CH_SPACE || c == CH_BSL || c == CH_SLASH) begin
          r        = token_char(c, ps.phase == PH_ESC_FIRST);
          ps.phase = PH_TOKEN;
        end else begin
          ps.phase = PH_ERROR;
        end
      end
      default: begin
        ps.phase = PH_ERROR;
      end
    endcase
    return r;
  endfunction

  // Channel monitor: register writes, then result words, then new bytes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim.max_options   = 8'd8;
      lim.max_arguments = 8'd8;
      lim.max_line_len  = 16'd256;
      clear_line();
      predicted_q.delete();
      fails   = 0;
      words   = 0;
      accepts = 0;
      rejects = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAX_OPTIONS:   lim.max_options   = cfg_data_i[7:0];
          REG_MAX_ARGUMENTS: lim.max_arguments = cfg_data_i[7:0];
          REG_MAX_LINE_LEN:  lim.max_line_len  = cfg_data_i;
          default: ;
        endcase
      end

      // A result word is matched against the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        if (predicted_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%t: result word with nothing predicted: status %0d char %h kind %0d",
                     $realtime, status_i, char_out_i, char_kind_i);
        end else begin
          want = predicted_q.pop_front();
          words++;
          if (want.status == ST_ACCEPT) accepts++;
          if (want.status == ST_REJECT) rejects++;
          if (status_i != want.status || char_out_i != want.char_out ||
              char_kind_i != want.char_kind || token_start_i != want.token_start ||
              token_index_i != want.token_index || value_expected_i != want.value_expected)
          begin
            fails++;
            if (fails <= 10) begin
              $display("%t: word %0d expected status %0d char %h kind %0d start %0b",
                       $realtime, words, want.status, want.char_out, want.char_kind,
                       want.token_start);
              $display("%t: word %0d expected index %0d vexp %0b",
                       $realtime, words, want.token_index, want.value_expected);
              $display("%t: word %0d got      status %0d char %h kind %0d start %0b",
                       $realtime, words, status_i, char_out_i, char_kind_i,
                       token_start_i);
              $display("%t: word %0d got      index %0d vexp %0b",
                       $realtime, words, token_index_i, value_expected_i);
            end
          end
        end
      end

      if (in_valid_i && !in_stall_i) predicted_q.push_back(tokenize_byte(ch_i));
    end
    fail_count_o <= fails;
    pending_o    <= predicted_q.size();
    words_o      <= words;
    accepts_o    <= accepts;
    rejects_o    <= rejects;
  end

endmodule

[sim/command_line_tokenizer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer testbench
// Feeds console lines to the tokenizer under several limit settings, with
// random gaps on the byte side and random stalls on the result side; the
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module command_line_tokenizer_tb;
  import clt_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  ch;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [7:0]  char_out;
  logic [2:0]  char_kind;
  logic        token_start;
  logic [7:0]  token_index;
  logic        value_expected;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int          errors;
  int          pending;
  int          words;
  int          accepts;
  int          rejects;

  // Stimulus bookkeeping.
  logic [7:0]  line_buf[$];
  int          bytes_sent;
  int          lines_sent;
  int          reg_writes;
  int          burst_left;
  logic        steady;

  command_line_tokenizer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .ch_i             (ch),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .char_out_o       (char_out),
    .char_kind_o      (char_kind),
    .token_start_o    (token_start),
    .token_index_o    (token_index),
    .value_expected_o (value_expected),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  command_line_tokenizer_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .ch_i             (ch),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .char_out_i       (char_out),
    .char_kind_i      (char_kind),
    .token_start_i    (token_start),
    .token_index_i    (token_index),
    .value_expected_i (value_expected),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (errors),
    .pending_o        (pending),
    .words_o          (words),
    .accepts_o        (accepts),
    .rejects_o        (rejects)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side stalls on a repeating frame with a random stalled head.
  initial begin
    int frame_pos;
    int hold;
    out_stall = 1'b0;
    frame_pos = 0;
    hold      = 0;
    forever begin
      @(negedge clk_i);
      if (frame_pos == 0) hold = steady ? 0 : $urandom_range(0, 6);
      out_stall = (frame_pos < hold);
      frame_pos = (frame_pos + 1) % 13;
    end
  end

  // Run limit.
  initial begin
    #25ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Presents one byte, after a random gap at the start of each burst, and
  // returns at the falling edge after the word is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid = 1'b1;
    ch       = b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    burst_left--;
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    send_byte(CH_NUL);
    lines_sent++;
  endtask

  function automatic void load_text(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    reg_writes++;
    @(negedge clk_i);
  endtask

  // Waits for every predicted word to come out, then sets all three limits.
  task automatic configure(input logic [7:0] opt, input logic [7:0] arg,
                           input logic [15:0] len);
    in_valid   = 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
    write_reg(REG_MAX_OPTIONS, {8'd0, opt});
    write_reg(REG_MAX_ARGUMENTS, {8'd0, arg});
    write_reg(REG_MAX_LINE_LEN, len);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] rand_alnum();
    int pick;
    pick = $urandom_range(0, 61);
    if (pick < 26) return CH_UA + 8'(pick);
    if (pick < 52) return CH_LA + 8'(pick - 26);
    return CH_D0 + 8'(pick - 52);
  endfunction

  // Printable token character; never a backslash, and no slash up front.
  function automatic logic [7:0] rand_token_char(input logic first);
    logic [7:0] c;
    c = 8'($urandom_range(8'h21, 8'h7E));
    while (c == CH_BSL || (first && c == CH_SLASH)) c = 8'($urandom_range(8'h21, 8'h7E));
    return c;
  endfunction

  task automatic add_name();
    repeat ($urandom_range(1, 3)) line_buf.push_back(rand_alnum());
  endtask

  // Argument or value token, with escaped space, backslash or slash mixed in.
  task automatic add_token();
    int n;
    logic [7:0] c;
    n = $urandom_range(1, 4);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        line_buf.push_back(CH_BSL);
        case ($urandom_range(0, 2))
          0:       c = CH_SPACE;
          1:       c = CH_BSL;
          default: c = CH_SLASH;
        endcase
        line_buf.push_back(c);
      end else begin
        line_buf.push_back(rand_token_char(k == 0));
      end
    end
  endtask

  // Mostly well-formed lines with random content; some noise, blank lines
  // and lines with one stray byte.
  task automatic build_line();
    int shape;
    int ntok;
    logic [7:0] b;
    line_buf.delete();
    shape = $urandom_range(0, 15);
    if (shape == 0) begin
      repeat ($urandom_range(0, 8)) begin
        b = 8'($urandom_range(1, 255));
        line_buf.push_back(b);
      end
    end else if (shape == 1) begin
      repeat ($urandom_range(0, 3)) line_buf.push_back(CH_SPACE);
    end else begin
      repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
      repeat ($urandom_range(1, 4)) line_buf.push_back(rand_alnum());
      ntok = $urandom_range(0, 4);
      for (int k = 0; k < ntok; k++) begin
        repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SPACE);
        case ($urandom_range(0, 3))
          0: begin
            // Option with its value, now and then left without one.
            line_buf.push_back(CH_SLASH);
            add_name();
            if ($urandom_range(0, 7) != 0) begin
              line_buf.push_back(CH_SPACE);
              add_token();
            end
          end
          1: begin
            line_buf.push_back(CH_SLASH);
            line_buf.push_back(CH_SLASH);
            add_name();
          end
          default: add_token();
        endcase
      end
      if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_SPACE);
      if (shape == 2) begin
        b = 8'($urandom_range(1, 255));
        line_buf.insert($urandom_range(0, line_buf.size()), b);
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] opt, input logic [7:0] arg,
                           input logic [15:0] len, input int nbytes);
    int stop_at;
    configure(opt, arg, len);
    stop_at = bytes_sent + nbytes;
    while (bytes_sent < stop_at) begin
      steady = ($urandom_range(0, 5) == 0);
      build_line();
      send_line();
    end
  endtask

  // A command followed by nothing but spaces, for the line length limit.
  task automatic long_line(input int spaces);
    send_byte(CH_LA);
    repeat (spaces) send_byte(CH_SPACE);
    send_byte(CH_NUL);
    lines_sent++;
  endtask

  // Main sequence.
  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    ch         = CH_NUL;
    cfg_valid  = 1'b0;
    cfg_index  = REG_MAX_OPTIONS;
    cfg_data   = 16'd0;
    steady     = 1'b0;
    bytes_sent = 0;
    lines_sent = 0;
    reg_writes = 0;
    burst_left = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed lines under the reset limits: empty line, command extremes with
    // an option value that starts with an escape and a flag, an argument with
    // escapes and the printable extremes, an option met while a value is
    // pending, and a bad byte followed by an ignored one.
    load_text("");
    send_line();
    load_text("Zz09 /a \\/b //q");
    send_line();
    load_text("A9 !\\ \\\\~");
    send_line();
    load_text("a /b /c");
    send_line();
    load_text("a");
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h62);
    send_line();

    // Random lines under a range of limits.
    run_phase(8'd0, 8'd0, 16'd1, 50);
    run_phase(8'd2, 8'd3, 16'd40, 100);
    run_phase(8'd255, 8'd255, 16'd65535, 80);

    // Terminator exactly at the length limit, then one byte past it.
    configure(8'd8, 8'd8, 16'd40);
    steady = 1'b1;
    long_line(38);
    steady = 1'b0;
    long_line(39);

    run_phase(8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
              16'($urandom_range(6, 48)), 100);
    run_phase(8'd1, 8'd0, 16'd200, 70);
    run_phase(8'd8, 8'd8, 16'd256, 80);

    // Drain.
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d bytes in %0d lines across %0d register writes.",
             bytes_sent, lines_sent, reg_writes);
    $display("Checked %0d result words; %0d lines accepted and %0d rejected.",
             words, accepts, rejects);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/clt_pkg.sv
rtl/core/clt_step.sv
rtl/core/command_line_tokenizer.sv
sim/command_line_tokenizer_checker.sv
sim/command_line_tokenizer_tb.sv
